FILE: src/ascon_pkg.sv
// Shared types and constants for the Ascon-AEAD128 cipher block.
// No dependencies; used by every module under src.
package ascon_pkg;

  // Packed widths of the stream payloads.
  localparam int unsigned DATA_W  = 136;
  localparam int unsigned LANE_W  = 64;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned IDX_W   = 4;

  // Full block size in bytes.
  localparam logic [COUNT_W-1:0] FULL_BYTES = 5'd16;

  // Configuration register indexes.
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_MODE     = 2'd2;

  // Input operations and result kinds.
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_TAG  = 1'b1;

  // Initial value and domain separation constant.
  localparam logic [LANE_W-1:0] ASCON_IV   = 64'h0000_1000_808C_0001;
  localparam logic [LANE_W-1:0] DOMAIN_BIT = 64'h8000_0000_0000_0000;

  // Round constant slots: 12 rounds start at slot 0, 8 rounds at slot 4.
  localparam logic [IDX_W-1:0] FIRST_OF_12 = 4'd0;
  localparam logic [IDX_W-1:0] FIRST_OF_8  = 4'd4;
  localparam logic [IDX_W-1:0] LAST_ROUND  = 4'd11;

  localparam logic [7:0] ROUND_CONST [12] = '{
    8'hF0, 8'hE1, 8'hD2, 8'hC3, 8'hB4, 8'hA5,
    8'h96, 8'h87, 8'h78, 8'h69, 8'h5A, 8'h4B
  };

  // The five 64-bit lanes of the permutation state.
  typedef logic [4:0][LANE_W-1:0] lanes_t;

  // Controls handed from the sequencer to the absorb logic.
  typedef struct packed {
    logic               decrypt;
    logic               pad_en;
    logic [COUNT_W-1:0] nbytes;
  } absorb_ctl_t;

endpackage

FILE: src/ascon_round.sv
// One round of the Ascon permutation: constant addition, S-box layer and
// linear diffusion layer. Depends on ascon_pkg.
module ascon_round (
  input  ascon_pkg::lanes_t            x,
  input  logic [ascon_pkg::IDX_W-1:0]  rc_idx,
  output ascon_pkg::lanes_t            y
);
  import ascon_pkg::*;

  function automatic logic [LANE_W-1:0] rotr(input logic [LANE_W-1:0] v,
                                              input int unsigned k);
    rotr = (v >> k) | (v << (LANE_W - k));
  endfunction

  always_comb begin
    lanes_t a;
    logic [LANE_W-1:0] t0, t1, t2, t3, t4;
    a = x;
    // Constant addition.
    a[2] = a[2] ^ {56'd0, ROUND_CONST[rc_idx]};
    // Substitution layer, bit-sliced 5-bit S-box.
    a[0] = a[0] ^ a[4];
    a[4] = a[4] ^ a[3];
    a[2] = a[2] ^ a[1];
    t0 = ~a[0] & a[1];
    t1 = ~a[1] & a[2];
    t2 = ~a[2] & a[3];
    t3 = ~a[3] & a[4];
    t4 = ~a[4] & a[0];
    a[0] = a[0] ^ t1;
    a[1] = a[1] ^ t2;
    a[2] = a[2] ^ t3;
    a[3] = a[3] ^ t4;
    a[4] = a[4] ^ t0;
    a[1] = a[1] ^ a[0];
    a[0] = a[0] ^ a[4];
    a[3] = a[3] ^ a[2];
    a[2] = ~a[2];
    // Linear diffusion layer.
    y[0] = a[0] ^ rotr(a[0], 19) ^ rotr(a[0], 28);
    y[1] = a[1] ^ rotr(a[1], 61) ^ rotr(a[1], 39);
    y[2] = a[2] ^ rotr(a[2], 1)  ^ rotr(a[2], 6);
    y[3] = a[3] ^ rotr(a[3], 10) ^ rotr(a[3], 17);
    y[4] = a[4] ^ rotr(a[4], 7)  ^ rotr(a[4], 41);
  end

endmodule

FILE: src/ascon_absorb.sv
// Rate absorption for one data block: byte masking, encrypt or decrypt,
// and the 0x01 padding byte of a short final block. Depends on ascon_pkg.
module ascon_absorb (
  input  logic [ascon_pkg::LANE_W-1:0] x0,
  input  logic [ascon_pkg::LANE_W-1:0] x1,
  input  logic [ascon_pkg::LANE_W-1:0] data_low,
  input  logic [ascon_pkg::LANE_W-1:0] data_high,
  input  ascon_pkg::absorb_ctl_t       ctl,
  output logic [ascon_pkg::LANE_W-1:0] x0_next,
  output logic [ascon_pkg::LANE_W-1:0] x1_next,
  output logic [ascon_pkg::LANE_W-1:0] out_low,
  output logic [ascon_pkg::LANE_W-1:0] out_high
);
  import ascon_pkg::*;

  logic [LANE_W-1:0] m0, m1, pad0, pad1;
  logic [LANE_W-1:0] p0, p1, s0, s1;

  // Byte masks and pad positions, one byte lane at a time.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      m0[8*b +: 8]   = (ctl.nbytes > COUNT_W'(b))     ? 8'hFF : 8'h00;
      m1[8*b +: 8]   = (ctl.nbytes > COUNT_W'(b + 8)) ? 8'hFF : 8'h00;
      pad0[8*b +: 8] = {7'd0, ctl.pad_en && (ctl.nbytes == COUNT_W'(b))};
      pad1[8*b +: 8] = {7'd0, ctl.pad_en && (ctl.nbytes == COUNT_W'(b + 8))};
    end
  end

  // Decryption replaces the rate by the ciphertext; encryption XORs it in.
  always_comb begin
    if (ctl.decrypt) begin
      p0 = (x0 ^ data_low) & m0;
      p1 = (x1 ^ data_high) & m1;
      s0 = x0 ^ p0;
      s1 = x1 ^ p1;
      out_low  = p0;
      out_high = p1;
    end else begin
      p0 = data_low & m0;
      p1 = data_high & m1;
      s0 = x0 ^ p0;
      s1 = x1 ^ p1;
      out_low  = s0 & m0;
      out_high = s1 & m1;
    end
    x0_next = s0 ^ pad0;
    x1_next = s1 ^ pad1;
  end

endmodule

FILE: src/ascon_aead128_cipher.sv
// Ascon-AEAD128 cipher top level: one permutation round per cycle under a sequencer.
// Start transaction: accept, then 12 rounds, no result.
// Data block: accept, absorb (result issued), then 8 rounds if not final.
// Final block: absorb, 8 more rounds when it holds 16 bytes, 12 rounds, then the tag.
// The single round unit sets the rate; the input is not ready while rounds run.
// Synchronous reset clears the state lanes, key, mode and all handshake state.
module ascon_aead128_cipher (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [ascon_pkg::LANE_W-1:0]  cfg_data,
  // Input stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ascon_pkg::DATA_W-1:0]  s_tdata,  // data_low, data_high, byte_count
  input  logic                          s_tuser,  // operation
  input  logic                          s_tlast,  // final_block
  // Result stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ascon_pkg::DATA_W-1:0]  m_tdata,  // out_low, out_high, out_bytes
  output logic                          m_tuser,  // result_kind
  output logic                          m_tlast   // last_of_run
);
  import ascon_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ABSORB = 2'd1;
  localparam logic [1:0] S_ROUND  = 2'd2;
  localparam logic [1:0] S_TAG    = 2'd3;

  // Action taken after the last round of a run.
  localparam logic [1:0] POST_INIT = 2'd0;
  localparam logic [1:0] POST_NONE = 2'd1;
  localparam logic [1:0] POST_PAD  = 2'd2;
  localparam logic [1:0] POST_TAG  = 2'd3;

  logic [1:0]         state;
  logic [1:0]         post;
  logic [IDX_W-1:0]   rc_idx;
  lanes_t             lanes;
  logic [LANE_W-1:0]  key_low, key_high;
  logic               cipher_mode;

  logic [LANE_W-1:0]  in_low, in_high;
  logic [COUNT_W-1:0] in_bytes;
  logic               in_final;

  logic [LANE_W-1:0]  out_low, out_high;
  logic [COUNT_W-1:0] out_bytes;
  logic               out_kind, out_last;

  lanes_t             round_out;
  absorb_ctl_t        actl;
  logic [LANE_W-1:0]  ab_x0, ab_x1, ab_lo, ab_hi;
  logic               out_free;
  logic [COUNT_W-1:0] s_bytes;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low     <= '0;
      key_high    <= '0;
      cipher_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_LOW:  key_low     <= cfg_data;
        REG_KEY_HIGH: key_high    <= cfg_data;
        REG_MODE:     cipher_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Shared round unit and absorb logic.
  ascon_round u_round (
    .x      (lanes),
    .rc_idx (rc_idx),
    .y      (round_out)
  );

  assign actl.decrypt = cipher_mode;
  assign actl.pad_en  = in_final && (in_bytes != FULL_BYTES);
  assign actl.nbytes  = in_bytes;

  ascon_absorb u_absorb (
    .x0        (lanes[0]),
    .x1        (lanes[1]),
    .data_low  (in_low),
    .data_high (in_high),
    .ctl       (actl),
    .x0_next   (ab_x0),
    .x1_next   (ab_x1),
    .out_low   (ab_lo),
    .out_high  (ab_hi)
  );

  // Byte count above sixteen, or on a non-final block, counts as a full block.
  assign s_bytes = (!s_tlast || s_tdata[132:128] > FULL_BYTES) ? FULL_BYTES
                                                                : s_tdata[132:128];

  // Sequencer and permutation state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      post   <= POST_NONE;
      rc_idx <= '0;
      lanes  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == OP_START) begin
              lanes  <= {s_tdata[127:64], s_tdata[63:0], key_high, key_low, ASCON_IV};
              rc_idx <= FIRST_OF_12;
              post   <= POST_INIT;
              state  <= S_ROUND;
            end else begin
              state <= S_ABSORB;
            end
          end
        end
        S_ABSORB: begin
          if (out_free) begin
            lanes[0] <= ab_x0;
            lanes[1] <= ab_x1;
            state    <= S_ROUND;
            if (!in_final) begin
              rc_idx <= FIRST_OF_8;
              post   <= POST_NONE;
            end else if (in_bytes == FULL_BYTES) begin
              rc_idx <= FIRST_OF_8;
              post   <= POST_PAD;
            end else begin
              lanes[2] <= lanes[2] ^ key_low;
              lanes[3] <= lanes[3] ^ key_high;
              rc_idx   <= FIRST_OF_12;
              post     <= POST_TAG;
            end
          end
        end
        S_ROUND: begin
          lanes <= round_out;
          if (rc_idx == LAST_ROUND) begin
            rc_idx <= '0;
            unique case (post)
              POST_INIT: begin
                lanes[3] <= round_out[3] ^ key_low;
                lanes[4] <= round_out[4] ^ key_high ^ DOMAIN_BIT;
                state    <= S_IDLE;
              end
              POST_PAD: begin
                // Empty padded block closes a message of whole blocks.
                lanes[0] <= round_out[0] ^ 64'd1;
                lanes[2] <= round_out[2] ^ key_low;
                lanes[3] <= round_out[3] ^ key_high;
                rc_idx   <= FIRST_OF_12;
                post     <= POST_TAG;
              end
              POST_TAG: state <= S_TAG;
              default:  state <= S_IDLE;
            endcase
          end else begin
            rc_idx <= rc_idx + IDX_W'(1);
          end
        end
        S_TAG: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Input holding registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_low   <= s_tdata[63:0];
      in_high  <= s_tdata[127:64];
      in_bytes <= s_bytes;
      in_final <= s_tlast;
    end
  end

  // Output register: data result from the absorb cycle, tag from the tag cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_ABSORB && out_free) begin
      m_tvalid <= 1'b1;
    end else if (state == S_TAG && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ABSORB && out_free) begin
      out_kind  <= KIND_DATA;
      out_low   <= ab_lo;
      out_high  <= ab_hi;
      out_bytes <= in_bytes;
      out_last  <= !in_final;
    end else if (state == S_TAG && out_free) begin
      out_kind  <= KIND_TAG;
      out_low   <= lanes[3] ^ key_low;
      out_high  <= lanes[4] ^ key_high;
      out_bytes <= FULL_BYTES;
      out_last  <= 1'b1;
    end
  end

  assign m_tdata = {3'd0, out_bytes, out_high, out_low};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

  // The round slot never runs past the last round constant.
  a_rc_bound: assert property (@(posedge clk) disable iff (rst)
    rc_idx <= LAST_ROUND)
    else $error("round slot out of range");

  // A run of rounds ends only after the last round constant.
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && state == S_IDLE && $past(state) == S_ROUND)
      |-> $past(rc_idx) == LAST_ROUND)
    else $error("round run left early");

  // A pending tag waits while the output register is still occupied.
  a_tag_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAG && !out_free) |=> state == S_TAG)
    else $error("tag dropped while output busy");

endmodule
